[rtl/core/dils_pkg.sv]
// Package for the decay and inflow level stepper.
// Holds field widths, fixed-point constants, register indexes and the structs
// that pass between the controller and the datapath. No dependencies.
package dils_pkg;

  localparam int LVL_W        = 48;
  localparam int DEC_W        = 32;
  localparam int DEC_FRAC     = 31;
  localparam int CNT_W        = 17;
  localparam int TIME_W       = 32;
  localparam int TFB          = 16;
  localparam int CHUNK_STEPS  = 100;
  localparam int TBL_AW       = $clog2(CHUNK_STEPS + 1);
  localparam int HALF_W       = LVL_W / 2;
  localparam int PROD_W       = HALF_W + DEC_W;
  localparam int RND_W        = PROD_W + HALF_W + 1;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 48;

  localparam logic [DEC_W-1:0] ONE_Q31 = DEC_W'(64'h8000_0000);
  localparam logic [LVL_W-1:0] LVL_MAX = {LVL_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INFLOW        = 2'd2;

  localparam logic MODE_ADD_TIME = 1'b0;

  localparam logic [1:0] SEL_POW = 2'd0;
  localparam logic [1:0] SEL_INF = 2'd1;
  localparam logic [1:0] SEL_LVL = 2'd2;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic              tbl_init;
    logic              tbl_wr;
    logic              rd_en;
    logic [TBL_AW-1:0] tbl_addr;
    logic              mul;
    logic              rnd;
    logic              add;
    logic [1:0]        sel;
    logic              time_add;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] step_count;
  } dp_stat_t;

endpackage

[rtl/core/dils_if.sv]
// Channel interfaces for the decay and inflow level stepper.
// Input item, result item and configuration write channels; uses dils_pkg.
interface dils_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [dils_pkg::TIME_W-1:0]   elapsed_time;
  modport source (output valid, output mode, output elapsed_time, input ready);
  modport sink (input valid, input mode, input elapsed_time, output ready);
endinterface

interface dils_out_if;
  logic                          valid;
  logic                          ready;
  logic [dils_pkg::LVL_W-1:0]    level;
  logic [dils_pkg::CNT_W-1:0]    pending_steps;
  modport source (output valid, output level, output pending_steps, input ready);
  modport sink (input valid, input level, input pending_steps, output ready);
endinterface

interface dils_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dils_pkg::CFG_IDX_W-1:0]  index;
  logic [dils_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/dils_dp.sv]
// Datapath of the decay and inflow level stepper: registers, both tables,
// the rounding multiply-add unit and the result register. Uses dils_pkg.
module dils_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dils_pkg::cfg_wr_t            cfg,
  input  dils_pkg::dp_cmd_t            cmd,
  input  logic [dils_pkg::TIME_W-1:0]  elapsed_time,
  output dils_pkg::dp_stat_t           stat,
  output logic [dils_pkg::LVL_W-1:0]   out_level,
  output logic [dils_pkg::CNT_W-1:0]   out_pending
);

  logic [dils_pkg::DEC_W-1:0]  decay_r;
  logic [dils_pkg::LVL_W-1:0]  inflow_r;
  logic [dils_pkg::LVL_W-1:0]  level_r;
  logic [dils_pkg::TFB-1:0]    frac_r;
  logic [dils_pkg::CNT_W-1:0]  count_r;
  logic [dils_pkg::DEC_W-1:0]  pw_prev_r;
  logic [dils_pkg::LVL_W-1:0]  inf_prev_r;
  logic [dils_pkg::DEC_W-1:0]  pw_rd_r;
  logic [dils_pkg::LVL_W-1:0]  inf_rd_r;
  logic [dils_pkg::PROD_W-1:0] ph_r;
  logic [dils_pkg::PROD_W-1:0] pl_r;
  logic [dils_pkg::LVL_W-1:0]  q_r;
  logic [dils_pkg::LVL_W-1:0]  out_level_r;
  logic [dils_pkg::CNT_W-1:0]  out_pending_r;

  logic [dils_pkg::DEC_W-1:0]  pw_mem  [0:dils_pkg::CHUNK_STEPS];
  logic [dils_pkg::LVL_W-1:0]  inf_mem [0:dils_pkg::CHUNK_STEPS];

  logic [dils_pkg::DEC_W-1:0]  eff_dec;
  logic [dils_pkg::LVL_W-1:0]  mul_x;
  logic [dils_pkg::DEC_W-1:0]  mul_m;
  logic [dils_pkg::LVL_W-1:0]  addend;
  logic [dils_pkg::RND_W-1:0]  rnd_sum;
  logic [dils_pkg::LVL_W:0]    add_sum;
  logic [dils_pkg::LVL_W-1:0]  add_res;
  logic [dils_pkg::TIME_W:0]   time_sum;
  logic [dils_pkg::TIME_W:0]   whole;
  logic [dils_pkg::CNT_W-1:0]  count_nxt;
  logic [dils_pkg::TFB-1:0]    frac_nxt;

  always_comb begin
    eff_dec = (decay_r > dils_pkg::ONE_Q31) ? dils_pkg::ONE_Q31 : decay_r;
    case (cmd.sel)
      dils_pkg::SEL_POW: begin
        mul_x  = dils_pkg::LVL_W'(pw_prev_r);
        mul_m  = eff_dec;
        addend = '0;
      end
      dils_pkg::SEL_INF: begin
        mul_x  = inf_prev_r;
        mul_m  = eff_dec;
        addend = inflow_r;
      end
      default: begin
        mul_x  = level_r;
        mul_m  = pw_rd_r;
        addend = inf_rd_r;
      end
    endcase
    rnd_sum = (dils_pkg::RND_W'(ph_r) << dils_pkg::HALF_W) + dils_pkg::RND_W'(pl_r)
              + (dils_pkg::RND_W'(1) << (dils_pkg::DEC_FRAC - 1));
    add_sum = {1'b0, q_r} + {1'b0, addend};
    add_res = add_sum[dils_pkg::LVL_W] ? dils_pkg::LVL_MAX : add_sum[dils_pkg::LVL_W-1:0];
    time_sum = (dils_pkg::TIME_W + 1)'(frac_r) + (dils_pkg::TIME_W + 1)'(elapsed_time);
    whole    = time_sum >> dils_pkg::TFB;
    frac_nxt = time_sum[dils_pkg::TFB-1:0];
    count_nxt = (whole > (dils_pkg::TIME_W + 1)'(dils_pkg::CNT_MAX)) ?
                dils_pkg::CNT_MAX : whole[dils_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r  <= dils_pkg::ONE_Q31;
      inflow_r <= '0;
      level_r  <= '0;
      frac_r   <= '0;
      count_r  <= '0;
    end else begin
      if (cfg.we) begin
        case (cfg.idx)
          dils_pkg::REG_INITIAL_LEVEL: begin
            level_r <= cfg.data[dils_pkg::LVL_W-1:0];
          end
          dils_pkg::REG_DECAY:  decay_r  <= cfg.data[dils_pkg::DEC_W-1:0];
          dils_pkg::REG_INFLOW: inflow_r <= cfg.data[dils_pkg::LVL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.add && cmd.sel == dils_pkg::SEL_LVL) begin
        level_r <= add_res;
      end
      if (cmd.time_add) begin
        frac_r  <= frac_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_init) begin
      pw_prev_r  <= dils_pkg::ONE_Q31;
      inf_prev_r <= '0;
    end else if (cmd.add && cmd.sel == dils_pkg::SEL_POW) begin
      pw_prev_r  <= add_res[dils_pkg::DEC_W-1:0];
    end else if (cmd.add && cmd.sel == dils_pkg::SEL_INF) begin
      inf_prev_r <= add_res;
    end
    if (cmd.mul) begin
      ph_r <= mul_x[dils_pkg::LVL_W-1:dils_pkg::HALF_W] * mul_m;
      pl_r <= mul_x[dils_pkg::HALF_W-1:0] * mul_m;
    end
    if (cmd.rnd) begin
      q_r <= rnd_sum[dils_pkg::DEC_FRAC+dils_pkg::LVL_W-1:dils_pkg::DEC_FRAC];
    end
    if (cmd.out_load) begin
      out_level_r   <= level_r;
      out_pending_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_init) begin
      pw_mem[0]  <= dils_pkg::ONE_Q31;
      inf_mem[0] <= '0;
    end else if (cmd.tbl_wr) begin
      pw_mem[cmd.tbl_addr]  <= pw_prev_r;
      inf_mem[cmd.tbl_addr] <= inf_prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      pw_rd_r  <= pw_mem[cmd.tbl_addr];
      inf_rd_r <= inf_mem[cmd.tbl_addr];
    end
  end

  assign stat.step_count = count_r;
  assign out_level       = out_level_r;
  assign out_pending     = out_pending_r;

endmodule

[rtl/core/dils_ctrl.sv]
// Controller of the decay and inflow level stepper: table rebuild sequence,
// chunked update sequence, item handshake and result valid. Uses dils_pkg.
module dils_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  dils_pkg::cfg_wr_t   cfg,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dils_pkg::dp_stat_t  stat,
  output dils_pkg::dp_cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_B_INIT = 3'd1;
  localparam logic [2:0] ST_B_WR   = 3'd2;
  localparam logic [2:0] ST_A_RD   = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_RND    = 3'd5;
  localparam logic [2:0] ST_ADD    = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  localparam logic [dils_pkg::CNT_W-1:0]  CHUNK_CNT = dils_pkg::CNT_W'(dils_pkg::CHUNK_STEPS);
  localparam logic [dils_pkg::TBL_AW-1:0] CHUNK_IDX = dils_pkg::TBL_AW'(dils_pkg::CHUNK_STEPS);

  logic [2:0]                 state_r, state_nxt;
  logic [1:0]                 sel_r, sel_nxt;
  logic [dils_pkg::TBL_AW-1:0] k_r, k_nxt;
  logic [dils_pkg::CNT_W-1:0] n_r, n_nxt;
  logic                       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.sel       = sel_r;
    cmd.tbl_addr  = k_r;
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == dils_pkg::MODE_ADD_TIME) begin
            cmd.time_add = 1'b1;
            state_nxt    = ST_FIN;
          end else begin
            n_nxt     = stat.step_count;
            state_nxt = ST_A_RD;
          end
        end
      end
      ST_B_INIT: begin
        cmd.tbl_init = 1'b1;
        k_nxt        = dils_pkg::TBL_AW'(1);
        sel_nxt      = dils_pkg::SEL_POW;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        case (sel_r)
          dils_pkg::SEL_POW: begin
            sel_nxt   = dils_pkg::SEL_INF;
            state_nxt = ST_MUL;
          end
          dils_pkg::SEL_INF: begin
            state_nxt = ST_B_WR;
          end
          default: begin
            if (n_r > CHUNK_CNT) begin
              n_nxt     = n_r - CHUNK_CNT;
              state_nxt = (n_nxt > CHUNK_CNT) ? ST_MUL : ST_A_RD;
            end else begin
              state_nxt = ST_FIN;
            end
          end
        endcase
      end
      ST_B_WR: begin
        cmd.tbl_wr = 1'b1;
        if (k_r == CHUNK_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          k_nxt     = k_r + dils_pkg::TBL_AW'(1);
          sel_nxt   = dils_pkg::SEL_POW;
          state_nxt = ST_MUL;
        end
      end
      ST_A_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.tbl_addr = (n_r > CHUNK_CNT) ? CHUNK_IDX : n_r[dils_pkg::TBL_AW-1:0];
        sel_nxt      = dils_pkg::SEL_LVL;
        state_nxt    = ST_MUL;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg.we && (cfg.idx == dils_pkg::REG_DECAY ||
                   cfg.idx == dils_pkg::REG_INFLOW)) begin
      state_nxt = ST_B_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_B_INIT;
      sel_r       <= dils_pkg::SEL_POW;
      k_r         <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/decay_inflow_level_stepper_unit.sv]
// Top level of the decay and inflow level stepper.
// Joins the controller and the datapath; uses dils_pkg and the dils channel
// interfaces.
//
// The block tracks one level under a per-step decay (Q1.31) and inflow (Q24.24).
// Channels: in_ch takes items of mode and elapsed_time, out_ch returns one item
// of level and pending_steps for every input item, cfg_ch writes the registers
// initial_level (0), decay (1) and inflow (2).
// A mode 0 item adds elapsed time; the finish state then loads its result
// into the output register. A mode 1 item applies the pending steps in chunks
// of one hundred, each chunk taking a multiply, a round and an add step through
// the shared rounding multiply-add unit, with a table read before the first
// chunk and, when there are more, again before the last one.
// One item is worked on at a time.
// After reset, and after every write of the decay or inflow register, the tables
// of decay powers and inflow sums are rebuilt; no item is taken meanwhile, and an
// item still in progress loses its result. Configuration writes are always accepted.
// The result sits in an output register, so the next item is taken while a
// result waits; a stalled receiver holds the block only when a second result
// is ready to leave.
module decay_inflow_level_stepper_unit (
  input  logic          clk,
  input  logic          rst_n,
  dils_in_if.sink       in_ch,
  dils_out_if.source    out_ch,
  dils_cfg_if.sink      cfg_ch
);

  dils_pkg::cfg_wr_t  cfg_wr;
  dils_pkg::dp_cmd_t  cmd;
  dils_pkg::dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.we    = cfg_ch.valid;
  assign cfg_wr.idx   = cfg_ch.index;
  assign cfg_wr.data  = cfg_ch.data;

  dils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_wr),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dils_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_wr),
    .cmd          (cmd),
    .elapsed_time (in_ch.elapsed_time),
    .stat         (stat),
    .out_level    (out_ch.level),
    .out_pending  (out_ch.pending_steps)
  );

endmodule

[bench/decay_inflow_level_stepper_unit_test.sv]
// Self-checking testbench for decay_inflow_level_stepper_unit.
// A clocked driver and monitor exchange items with the block, and a built-in predictor of
// level, step count and tables checks each result. Depends on dils_pkg and the dils interfaces.
module decay_inflow_level_stepper_unit_test;

  localparam logic MODE_APPLY = !dils_pkg::MODE_ADD_TIME;
  localparam logic [dils_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int   RX_HOLD_CYCLES = 400;
  localparam int   TAIL_CYCLES    = 2000;
  localparam int   MAX_REPORTS    = 200;

  typedef struct packed {
    logic                        mode;
    logic [dils_pkg::TIME_W-1:0] elapsed;
  } step_cmd_t;

  typedef struct packed {
    logic [dils_pkg::LVL_W-1:0] level;
    logic [dils_pkg::CNT_W-1:0] steps;
  } level_result_t;

  logic clk;
  logic rst_n;

  dils_in_if  in_ch();
  dils_out_if out_ch();
  dils_cfg_if cfg_ch();

  decay_inflow_level_stepper_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predicted state of the block.
  logic [dils_pkg::LVL_W-1:0] lvl_q;
  logic [dils_pkg::TFB-1:0]   frac_q;
  logic [dils_pkg::CNT_W-1:0] count_q;
  logic [dils_pkg::DEC_W-1:0] decay_reg;
  logic [dils_pkg::LVL_W-1:0] inflow_reg;
  logic [dils_pkg::DEC_W-1:0] pow_tab [0:dils_pkg::CHUNK_STEPS];
  logic [dils_pkg::LVL_W-1:0] sum_tab [0:dils_pkg::CHUNK_STEPS];

  step_cmd_t     step_cmd_q [$];
  level_result_t level_due_q [$];
  step_cmd_t     cur_cmd;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            err_count;
  int            hold_left;
  bit            hold_tog;
  bit            hold_seen;

  function automatic logic [dils_pkg::LVL_W-1:0] scale_q31(
      input logic [dils_pkg::LVL_W-1:0] a, input logic [dils_pkg::DEC_W-1:0] d);
    logic [dils_pkg::LVL_W+dils_pkg::DEC_W:0] p;
    p = a * d + (1 << 30);
    return p[dils_pkg::DEC_FRAC +: dils_pkg::LVL_W];
  endfunction

  function automatic logic [dils_pkg::LVL_W-1:0] sat_sum(
      input logic [dils_pkg::LVL_W-1:0] a, input logic [dils_pkg::LVL_W-1:0] b);
    logic [dils_pkg::LVL_W:0] s;
    s = a + b;
    return s[dils_pkg::LVL_W] ? dils_pkg::LVL_MAX : s[dils_pkg::LVL_W-1:0];
  endfunction

  function automatic void rebuild_tables();
    logic [dils_pkg::DEC_W-1:0] d;
    d = (decay_reg > dils_pkg::ONE_Q31) ? dils_pkg::ONE_Q31 : decay_reg;
    pow_tab[0] = dils_pkg::ONE_Q31;
    sum_tab[0] = '0;
    for (int k = 1; k <= dils_pkg::CHUNK_STEPS; k++) begin
      pow_tab[k] = dils_pkg::DEC_W'(scale_q31(dils_pkg::LVL_W'(pow_tab[k-1]), d));
      sum_tab[k] = sat_sum(scale_q31(sum_tab[k-1], d), inflow_reg);
    end
  endfunction

  function automatic void apply_chunk(input int k);
    lvl_q = sat_sum(scale_q31(lvl_q, pow_tab[k]), sum_tab[k]);
  endfunction

  function automatic void update_register(input logic [dils_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [dils_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      dils_pkg::REG_INITIAL_LEVEL: begin
        lvl_q = val[dils_pkg::LVL_W-1:0];
      end
      dils_pkg::REG_DECAY: begin
        decay_reg = val[dils_pkg::DEC_W-1:0];
        rebuild_tables();
      end
      dils_pkg::REG_INFLOW: begin
        inflow_reg = val[dils_pkg::LVL_W-1:0];
        rebuild_tables();
      end
      default: ;
    endcase
  endfunction

  function automatic level_result_t predict_level(input step_cmd_t c);
    logic [dils_pkg::TIME_W:0]              total;
    logic [dils_pkg::TIME_W-dils_pkg::TFB:0] whole;
    int                                     n;
    level_result_t                          r;
    if (c.mode == dils_pkg::MODE_ADD_TIME) begin
      total   = {1'b0, c.elapsed} + (dils_pkg::TIME_W + 1)'(frac_q);
      whole   = total[dils_pkg::TIME_W:dils_pkg::TFB];
      frac_q  = total[dils_pkg::TFB-1:0];
      count_q = (whole > dils_pkg::CNT_MAX) ? dils_pkg::CNT_MAX : dils_pkg::CNT_W'(whole);
    end else begin
      n = int'(count_q);
      while (n > dils_pkg::CHUNK_STEPS) begin
        apply_chunk(dils_pkg::CHUNK_STEPS);
        n -= dils_pkg::CHUNK_STEPS;
      end
      apply_chunk(n);
    end
    r.level = lvl_q;
    r.steps = count_q;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        level_due_q.push_back(predict_level(cur_cmd));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (step_cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_cmd = step_cmd_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.mode         <= cur_cmd.mode;
          in_ch.elapsed_time <= cur_cmd.elapsed;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    level_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (level_due_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: unexpected item, expected none, got level %h steps %h",
                     $time, out_ch.level, out_ch.pending_steps);
        end else begin
          want = level_due_q.pop_front();
          if (out_ch.level !== want.level) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: level mismatch, expected %h, got %h",
                       $time, want.level, out_ch.level);
          end
          if (out_ch.pending_steps !== want.steps) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: pending_steps mismatch, expected %h, got %h",
                       $time, want.steps, out_ch.pending_steps);
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= RX_HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic logic [dils_pkg::LVL_W-1:0] rnd48();
    return dils_pkg::LVL_W'({$urandom, $urandom});
  endfunction

  function automatic logic [dils_pkg::TIME_W-1:0] rand_elapsed();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(0, 32'h0018_FFFF);
    if (sel < 95) return $urandom_range(0, 32'h03FF_FFFF);
    return $urandom;
  endfunction

  function automatic logic [dils_pkg::CFG_DATA_W-1:0] pick_decay();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return dils_pkg::CFG_DATA_W'(dils_pkg::ONE_Q31);
    if (sel < 25) return '0;
    if (sel < 35) return {16'($urandom), 32'($urandom)};
    return dils_pkg::CFG_DATA_W'($urandom_range(32'h7000_0000, 32'h8000_0000));
  endfunction

  function automatic logic [dils_pkg::CFG_DATA_W-1:0] pick_inflow();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return dils_pkg::LVL_MAX;
    if (sel < 25) return '0;
    return dils_pkg::CFG_DATA_W'($urandom_range(0, 32'h0400_0000));
  endfunction

  function automatic void add_cmd(input logic mode, input logic [dils_pkg::TIME_W-1:0] et);
    step_cmd_t c;
    c.mode    = mode;
    c.elapsed = et;
    step_cmd_q.push_back(c);
  endfunction

  function automatic void add_random(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        add_cmd(dils_pkg::MODE_ADD_TIME, rand_elapsed());
        add_cmd(MODE_APPLY, $urandom);
      end else if (sel < 85) begin
        add_cmd(MODE_APPLY, $urandom);
      end else begin
        add_cmd(dils_pkg::MODE_ADD_TIME, rand_elapsed());
      end
    end
  endfunction

  task automatic write_reg(input logic [dils_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dils_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    update_register(idx, val);
  endtask

  task automatic start_phase(input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic settle();
    while (step_cmd_q.size() != 0 || in_ch.valid || level_due_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    #100_000_000;
    $display("FAIL decay_inflow_level_stepper_unit");
    $finish;
  end

  initial begin
    int send_tab [4];
    int recv_tab [4];
    send_tab = '{0, 80, 0, 16};
    recv_tab = '{0, 0, 80, 16};
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = dils_pkg::MODE_ADD_TIME;
    in_ch.elapsed_time = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = dils_pkg::REG_INITIAL_LEVEL;
    cfg_ch.data        = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    err_count          = 0;
    lvl_q              = '0;
    frac_q             = '0;
    count_q            = '0;
    decay_reg          = dils_pkg::ONE_Q31;
    inflow_reg         = '0;
    rebuild_tables();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: nothing pending, level stays at zero.
    start_phase(0, 0);
    add_cmd(MODE_APPLY, 32'hFFFF_FFFF);
    add_cmd(dils_pkg::MODE_ADD_TIME, 32'h0000_0000);
    settle();

    write_reg(dils_pkg::REG_INITIAL_LEVEL, 48'h0000_0A00_0000);
    write_reg(dils_pkg::REG_DECAY, 48'h0000_4000_0000);
    write_reg(dils_pkg::REG_INFLOW, 48'h0000_0100_0000);
    start_phase(0, 0);
    add_cmd(dils_pkg::MODE_ADD_TIME, 32'h0000_8000);
    add_cmd(dils_pkg::MODE_ADD_TIME, 32'h0000_8000);
    add_cmd(MODE_APPLY, 32'h0000_0000);
    add_cmd(MODE_APPLY, 32'h1234_5678);
    add_cmd(dils_pkg::MODE_ADD_TIME, 32'd100 << 16);
    add_cmd(MODE_APPLY, 32'h0);
    add_cmd(dils_pkg::MODE_ADD_TIME, 32'd101 << 16);
    add_cmd(MODE_APPLY, 32'h0);
    add_cmd(dils_pkg::MODE_ADD_TIME, (32'd250 << 16) | 32'hFFFF);
    add_cmd(MODE_APPLY, 32'h0);
    add_cmd(dils_pkg::MODE_ADD_TIME, 32'hFFFF_FFFF);
    add_cmd(MODE_APPLY, 32'h0);
    add_cmd(dils_pkg::MODE_ADD_TIME, 32'h0000_0001);
    add_cmd(dils_pkg::MODE_ADD_TIME, 32'h0000_0000);
    add_cmd(MODE_APPLY, 32'h0);
    settle();

    // A decay above one acts as one, so the maximum inflow drives the level to saturation.
    write_reg(dils_pkg::REG_INITIAL_LEVEL, dils_pkg::LVL_MAX);
    write_reg(dils_pkg::REG_DECAY, 48'hFFFF_FFFF_FFFF);
    write_reg(dils_pkg::REG_INFLOW, dils_pkg::LVL_MAX);
    start_phase(0, 0);
    add_cmd(dils_pkg::MODE_ADD_TIME, 32'd5 << 16);
    add_cmd(MODE_APPLY, 32'h0);
    add_cmd(dils_pkg::MODE_ADD_TIME, 32'hFFFF_FFFF);
    add_cmd(MODE_APPLY, 32'h0);
    settle();

    write_reg(dils_pkg::REG_INITIAL_LEVEL, '0);
    write_reg(dils_pkg::REG_DECAY, '0);
    write_reg(dils_pkg::REG_INFLOW, 48'h1);
    write_reg(REG_UNUSED, rnd48());
    start_phase(0, 0);
    add_cmd(dils_pkg::MODE_ADD_TIME, 32'd3 << 16);
    add_cmd(MODE_APPLY, 32'h0);
    add_cmd(MODE_APPLY, 32'h0);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 0) write_reg(dils_pkg::REG_DECAY, pick_decay());
      if (ph % 3 == 1) write_reg(dils_pkg::REG_INFLOW, pick_inflow());
      if (ph % 2 == 0) write_reg(dils_pkg::REG_INITIAL_LEVEL, rnd48());
      if (ph == 5) write_reg(REG_UNUSED, rnd48());
      start_phase(send_tab[ph % 4], recv_tab[ph % 4]);
      if (ph == 4) hold_tog = !hold_tog;
      add_random(42);
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS decay_inflow_level_stepper_unit");
    end else begin
      $display("FAIL decay_inflow_level_stepper_unit");
    end
    $finish;
  end

endmodule
